FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted (active-low reset).
`define EVAG_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs during reset.
`define EVAG_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/evag_pkg.sv
// Shared types and constants for the energy voice activity gate.
// No dependencies.
`default_nettype none

package evag_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int THR_W         = 15;
    localparam int HANG_W        = 8;
    localparam int SAMPLES_W     = 13;
    localparam int SQ_W          = 31;   // largest square is 32768^2
    localparam int MUL_A_W       = 30;   // threshold squared
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int MAX_FRAME_DEF = 4096;

    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(200);
    localparam logic [HANG_W-1:0] HANG_RESET = HANG_W'(10);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE    = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_HANGOVER  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic              enable;
        logic [THR_W-1:0]  level_threshold;
        logic [HANG_W-1:0] hangover_frames;
    } cfg_t;

endpackage

`default_nettype wire

FILE: src/evag_cfg.sv
// Configuration register file of the voice activity gate.
// Depends on evag_pkg.
`default_nettype none

module evag_cfg
    import evag_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable          <= 1'b0;
            cfg_reg.level_threshold <= THR_RESET;
            cfg_reg.hangover_frames <= HANG_RESET;
        end else if (cfg_valid) begin
            // unknown index: drop the write
            unique case (cfg_reg_t'(cfg_index))
                REG_ENABLE:    cfg_reg.enable          <= cfg_data[0];
                REG_THRESHOLD: cfg_reg.level_threshold <= cfg_data[THR_W-1:0];
                REG_HANGOVER:  cfg_reg.hangover_frames <= cfg_data[HANG_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/evag_mul.sv
// Shared unsigned multiplier with registered product.
// Depends on evag_pkg for the default operand widths; operand widths are parameters.
`default_nettype none

module evag_mul
    import evag_pkg::*;
#(
    parameter int A_W = MUL_A_W,
    parameter int B_W = SAMPLE_W
) (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic [A_W-1:0]     op_a,
    input  wire logic [B_W-1:0]     op_b,
    output logic      [A_W+B_W-1:0] prod
);

    logic [A_W+B_W-1:0] prod_reg;

    assign prod = prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= op_a * op_b;
        end
    end

endmodule

`default_nettype wire

FILE: src/evag_ctrl.sv
// Sequencer and datapath: accumulates squares, scales the threshold, decides.
// Depends on evag_pkg; drives the shared multiplier evag_mul.
`default_nettype none

module evag_ctrl
    import evag_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF,
    parameter int CNT_W     = $clog2(MAX_FRAME + 1),
    parameter int B_W       = (CNT_W > SAMPLE_W) ? CNT_W : SAMPLE_W,
    parameter int P_W       = MUL_A_W + B_W
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cfg_t                 cfg,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [SAMPLE_W-1:0]  s_sample,
    input  wire logic                 s_frame_end,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_transmit,
    output logic                      m_loud,
    output logic [SAMPLES_W-1:0]      m_frame_samples,
    output logic                      mul_en,
    output logic [MUL_A_W-1:0]        mul_a,
    output logic [B_W-1:0]            mul_b,
    input  wire logic [P_W-1:0]       mul_prod
);

    localparam int E_W   = SQ_W + $clog2(MAX_FRAME);
    localparam int CMP_W = (E_W > P_W) ? E_W : P_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_SCALE,
        ST_DECIDE
    } state_t;

    state_t              state_reg;
    logic [SAMPLE_W-1:0] mag_reg;
    logic                last_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [E_W-1:0]      energy_reg;
    logic [HANG_W-1:0]   hang_reg;
    logic                m_valid_reg;
    logic                m_transmit_reg;
    logic                m_loud_reg;
    logic [SAMPLES_W-1:0] m_samples_reg;

    logic [SAMPLE_W-1:0] mag;
    logic                frame_done;
    logic                loud;
    logic                out_free;

    assign mag = s_sample[SAMPLE_W-1] ? SAMPLE_W'(-s_sample) : s_sample;
    assign frame_done = last_reg || (count_reg >= CNT_W'(MAX_FRAME));
    assign loud = cfg.enable &&
                  (CMP_W'(energy_reg) >= CMP_W'(mul_prod));
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_transmit      = m_transmit_reg;
    assign m_loud          = m_loud_reg;
    assign m_frame_samples = m_samples_reg;

    // square the sample, then threshold squared, then scale by the count
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            ST_SQUARE: begin
                mul_a = MUL_A_W'(mag_reg);
                mul_b = B_W'(mag_reg);
            end
            ST_ACCUM: begin
                mul_a = MUL_A_W'(cfg.level_threshold);
                mul_b = B_W'(cfg.level_threshold);
            end
            ST_SCALE: begin
                mul_a = mul_prod[MUL_A_W-1:0];
                mul_b = B_W'(count_reg);
            end
            ST_IDLE, ST_DECIDE: begin
                mul_en = 1'b0;
            end
            default: mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            energy_reg  <= '0;
            hang_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_DECIDE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        mag_reg   <= mag;
                        last_reg  <= s_frame_end;
                        count_reg <= count_reg + 1'b1;
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE: begin
                    state_reg <= ST_ACCUM;
                end
                ST_ACCUM: begin
                    energy_reg <= energy_reg + E_W'(mul_prod[SQ_W-1:0]);
                    state_reg  <= frame_done ? ST_SCALE : ST_IDLE;
                end
                ST_SCALE: begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    // hold until the output register is free
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        m_loud_reg     <= loud;
                        m_samples_reg  <= SAMPLES_W'(count_reg);
                        m_transmit_reg <= loud || (cfg.enable && (hang_reg != '0));
                        if (cfg.enable) begin
                            if (loud) begin
                                hang_reg <= cfg.hangover_frames;
                            end else if (hang_reg != '0) begin
                                hang_reg <= hang_reg - 1'b1;
                            end
                        end
                        energy_reg <= '0;
                        count_reg  <= '0;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/energy_voice_activity_gate_unit.sv
// Energy voice activity gate: one sample per item, one result per frame.
// A sample passes through square and accumulate; the last of a frame also goes
// through scale and decide, waiting there for a free output register. No sample
// is taken meanwhile; one shared multiplier does square, threshold squared, scale.
// Reset (aresetn low, synchronous) clears the sums, the hangover counter and the
// output, and loads enable 0, threshold 200, hangover 10.
`default_nettype none

module energy_voice_activity_gate_unit
    import evag_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [SAMPLE_W-1:0]   s_sample,
    input  wire logic                  s_frame_end,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_transmit,
    output logic                       m_loud,
    output logic [SAMPLES_W-1:0]       m_frame_samples
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int B_W   = (CNT_W > SAMPLE_W) ? CNT_W : SAMPLE_W;
    localparam int P_W   = MUL_A_W + B_W;

    cfg_t               cfg;
    logic               mul_en;
    logic [MUL_A_W-1:0] mul_a;
    logic [B_W-1:0]     mul_b;
    logic [P_W-1:0]     mul_prod;

    evag_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    evag_mul #(
        .A_W (MUL_A_W),
        .B_W (B_W)
    ) u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    evag_ctrl #(
        .MAX_FRAME (MAX_FRAME),
        .CNT_W     (CNT_W),
        .B_W       (B_W),
        .P_W       (P_W)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_frame_end     (s_frame_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_transmit      (m_transmit),
        .m_loud          (m_loud),
        .m_frame_samples (m_frame_samples),
        .mul_en          (mul_en),
        .mul_a           (mul_a),
        .mul_b           (mul_b),
        .mul_prod        (mul_prod)
    );

endmodule

`default_nettype wire

FILE: src/evag_checker.sv
// Port-level checker for the voice activity gate, bound to the top level.
// Depends on evag_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module evag_checker
    import evag_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic                  m_transmit,
    input wire logic                  m_loud,
    input wire logic [SAMPLES_W-1:0]  m_frame_samples
);

    `EVAG_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (s_ready && !m_valid), "reset must leave block idle with no result")
    `EVAG_ASSERT(a_busy_after_accept, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "block must be busy after taking an item")
    `EVAG_ASSERT(a_loud_sends, aclk, aresetn, (m_valid && m_loud) |-> m_transmit, "loud frame must be transmitted")
    `EVAG_ASSERT(a_result_holds, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_transmit) && $stable(m_loud) && $stable(m_frame_samples)), "stalled result must hold")

endmodule

bind energy_voice_activity_gate_unit evag_checker u_evag_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_transmit      (m_transmit),
    .m_loud          (m_loud),
    .m_frame_samples (m_frame_samples)
);

`default_nettype wire
